[rtl/core/gfe_pkg.sv]
package gfe_pkg;

  // payload of one point and of one field result
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
  } field_t;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_COEF = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAGNITUDE  = 1'd1;

  localparam logic [31:0] WIDTH_COEF_RESET = 32'h0100_0000;
  localparam logic [31:0] MAGNITUDE_RESET  = 32'h0001_0000;

  // fixed-point constants
  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [28:0] EXP_CUTOFF = 29'd17 << 24;
  localparam logic [23:0] G_MAX      = 24'hFF_FFFF;

  // exponential pipeline depth
  localparam int HORNER_STEPS = 9;
  localparam int EXP_LAT      = 3 + 2 * HORNER_STEPS;

  // exponent argument beat from the front end
  typedef struct packed {
    logic        valid;
    logic        far;
    logic [28:0] t;
  } arg_t;

  // gaussian weight beat from the exponential unit
  typedef struct packed {
    logic        valid;
    logic [23:0] g;
  } gain_t;

  // per-point data that bypasses the exponential unit
  typedef struct packed {
    logic [39:0] m_yz;
    logic [39:0] m_xz;
    logic [39:0] m_xy;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
  } side_t;

  // magnitude of a two's complement word
  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // reciprocal multiplier for exact floor division by a small constant
  function automatic logic [32:0] recip_mul(input logic [3:0] d);
    case (d)
      4'd1:    return 33'd4294967296;
      4'd2:    return 33'd4294967296;
      4'd3:    return 33'd5726623062;
      4'd4:    return 33'd4294967296;
      4'd5:    return 33'd6871947674;
      4'd6:    return 33'd5726623062;
      4'd7:    return 33'd4908534053;
      4'd8:    return 33'd4294967296;
      4'd9:    return 33'd7635497416;
      default: return 33'd4294967296;
    endcase
  endfunction

  function automatic logic [5:0] recip_shift(input logic [3:0] d);
    case (d)
      4'd1:    return 6'd32;
      4'd2:    return 6'd33;
      4'd3:    return 6'd34;
      4'd4:    return 6'd34;
      4'd5:    return 6'd35;
      4'd6:    return 6'd35;
      4'd7:    return 6'd35;
      4'd8:    return 6'd35;
      4'd9:    return 6'd36;
      default: return 6'd32;
    endcase
  endfunction

endpackage

[rtl/core/gfe_front.sv]
module gfe_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  gfe_pkg::point_t     point,
  input  logic [31:0]         width_coef,
  output gfe_pkg::arg_t       arg,
  output gfe_pkg::side_t      side
);

  logic        v0, v1, v2, v3, v4;
  logic [31:0] ax, ay, az;
  logic        sx, sy, sz;
  logic [63:0] sq_x, sq_y, sq_z;
  logic [39:0] r2;
  logic [51:0] ph, pl;
  logic        far;
  logic [28:0] t;
  gfe_pkg::side_t side1, side2, side3, side4;

  logic [63:0] p_yz, p_xz, p_xy;
  logic [65:0] sq_sum;
  logic [72:0] t_sum;
  logic [48:0] t_full;
  logic        far_next;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // pair products and square sum
  always_comb begin
    p_yz   = 64'(ay) * 64'(az);
    p_xz   = 64'(ax) * 64'(az);
    p_xy   = 64'(ax) * 64'(ay);
    sq_sum = 66'(sq_x) + 66'(sq_y) + 66'(sq_z);
  end

  // scaled argument, far points at or beyond the cutoff are flagged
  always_comb begin
    t_sum    = {1'b0, ph, 20'd0} + 73'(pl);
    t_full   = t_sum[72:24];
    far_next = (ph[51:40] != 12'd0) || (t_full >= 49'(gfe_pkg::EXP_CUTOFF));
  end

  always_ff @(posedge clk) begin
    // stage 0: magnitudes and signs
    ax <= gfe_pkg::abs32(point.pos_x);
    ay <= gfe_pkg::abs32(point.pos_y);
    az <= gfe_pkg::abs32(point.pos_z);
    sx <= point.pos_x[31];
    sy <= point.pos_y[31];
    sz <= point.pos_z[31];
    // stage 1: squares and pair products
    sq_x <= 64'(ax) * 64'(ax);
    sq_y <= 64'(ay) * 64'(ay);
    sq_z <= 64'(az) * 64'(az);
    side1.m_yz  <= p_yz[63:24];
    side1.m_xz  <= p_xz[63:24];
    side1.m_xy  <= p_xy[63:24];
    side1.neg_x <= sx;
    side1.neg_y <= sy;
    side1.neg_z <= sz;
    // stage 2: squared radius
    r2    <= sq_sum[63:24];
    side2 <= side1;
    // stage 3: width products
    ph    <= 52'(width_coef) * 52'(r2[39:20]);
    pl    <= 52'(width_coef) * 52'(r2[19:0]);
    side3 <= side2;
    // stage 4: exponent argument
    far   <= far_next;
    t     <= t_full[28:0];
    side4 <= side3;
  end

  assign arg.valid = v4;
  assign arg.far   = far;
  assign arg.t     = t;
  assign side      = side4;

endmodule

[rtl/core/gfe_exp.sv]
module gfe_exp (
  input  logic           clk,
  input  logic           rst,
  input  gfe_pkg::arg_t  arg,
  output gfe_pkg::gain_t gain
);

  localparam int N = gfe_pkg::HORNER_STEPS;

  logic        e1_v, e2_v, g_v;
  logic        e1_far, e2_far;
  logic [4:0]  e1_n, e2_n;
  logic [23:0] e1_f;
  logic [31:0] e2_w;
  logic [23:0] g;

  logic        st_v   [0:N];
  logic        st_far [0:N];
  logic [4:0]  st_n   [0:N];
  logic [31:0] st_w   [0:N];
  logic [31:0] st_d   [0:N];

  logic [59:0] u_prod;
  logic [55:0] w_prod;

  assign u_prod = 60'(arg.t) * 60'(gfe_pkg::LOG2E_Q30);
  assign w_prod = 56'(e1_f) * 56'(gfe_pkg::LN2_Q32);

  // split into power of two and fraction, then scale fraction by ln 2
  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
      e2_v <= 1'b0;
    end else begin
      e1_v <= arg.valid;
      e2_v <= e1_v;
    end
  end

  always_ff @(posedge clk) begin
    e1_far <= arg.far;
    e1_n   <= u_prod[58:54];
    e1_f   <= u_prod[53:30];
    e2_far <= e1_far;
    e2_n   <= e1_n;
    e2_w   <= w_prod[55:24];
  end

  assign st_v[0]   = e2_v;
  assign st_far[0] = e2_far;
  assign st_n[0]   = e2_n;
  assign st_w[0]   = e2_w;
  assign st_d[0]   = 32'd0;

  // horner steps for exp(-w), divisors nine down to one
  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [3:0]  DIV = 4'(N - j);
    localparam logic [32:0] MUL = gfe_pkg::recip_mul(DIV);
    localparam logic [5:0]  SH  = gfe_pkg::recip_shift(DIV);

    logic        a_v, a_far;
    logic [4:0]  a_n;
    logic [31:0] a_w, a_q;
    logic [32:0] s;
    logic [64:0] ws_prod;
    logic [64:0] qm_prod;
    logic [64:0] qm_shift;

    always_comb begin
      s        = {1'b1, 32'd0} - {1'b0, st_d[j]};
      ws_prod  = 65'(st_w[j]) * 65'(s);
      qm_prod  = 65'(a_q) * 65'(MUL);
      qm_shift = qm_prod >> SH;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v       <= 1'b0;
        st_v[j+1] <= 1'b0;
      end else begin
        a_v       <= st_v[j];
        st_v[j+1] <= a_v;
      end
    end

    always_ff @(posedge clk) begin
      a_far       <= st_far[j];
      a_n         <= st_n[j];
      a_w         <= st_w[j];
      a_q         <= ws_prod[63:32];
      st_far[j+1] <= a_far;
      st_n[j+1]   <= a_n;
      st_w[j+1]   <= a_w;
      st_d[j+1]   <= qm_shift[31:0];
    end
  end

  // scale by the power of two with rounding, clip just below one
  logic [32:0] s_fin;
  logic [39:0] rnd;
  logic [39:0] g_sum;
  logic [39:0] g_shift;
  logic [5:0]  n_ext;

  always_comb begin
    n_ext   = {1'b0, st_n[N]};
    s_fin   = {1'b1, 32'd0} - {1'b0, st_d[N]};
    rnd     = 40'd1 << (n_ext + 6'd7);
    g_sum   = 40'(s_fin) + rnd;
    g_shift = g_sum >> (n_ext + 6'd8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else begin
      g_v <= st_v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (st_far[N]) begin
      g <= 24'd0;
    end else if (g_shift > 40'(gfe_pkg::G_MAX)) begin
      g <= gfe_pkg::G_MAX;
    end else begin
      g <= g_shift[23:0];
    end
  end

  assign gain.valid = g_v;
  assign gain.g     = g;

endmodule

[rtl/core/gfe_field.sv]
module gfe_field (
  input  logic            clk,
  input  logic            rst,
  input  gfe_pkg::gain_t  gain,
  input  gfe_pkg::side_t  side,
  input  logic [31:0]     magnitude,
  output logic            done,
  output gfe_pkg::field_t field
);

  logic        f1_v, f2_v;
  logic [39:0] v_yz, v_xz, v_xy;
  logic        n1_x, n1_y, n1_z;
  logic [55:0] hi_yz, lo_yz, hi_xz, lo_xz, hi_xy, lo_xy;
  logic        n2_x, n2_y, n2_z;

  logic [31:0] bmag;
  logic        sb;
  logic [63:0] pv_yz, pv_xz, pv_xy;
  logic [56:0] sum_yz, sum_xz, sum_xy;

  // sign/magnitude; user keeps registers stable while points in flight
  assign bmag = gfe_pkg::abs32(magnitude);
  assign sb   = magnitude[31];

  assign pv_yz = 64'(side.m_yz) * 64'(gain.g);
  assign pv_xz = 64'(side.m_xz) * 64'(gain.g);
  assign pv_xy = 64'(side.m_xy) * 64'(gain.g);

  always_comb begin
    sum_yz = 57'(hi_yz) + 57'(lo_yz[55:16]);
    sum_xz = 57'(hi_xz) + 57'(lo_xz[55:16]);
    sum_xy = 57'(hi_xy) + 57'(lo_xy[55:16]);
  end

  // apply sign and saturate to 32 bits
  function automatic logic [31:0] finish(input logic [48:0] mag, input logic neg);
    logic [48:0] lim;
    lim = 49'd0;
    if (mag == 49'd0) begin
      return 32'd0;
    end
    if (neg) begin
      lim = (mag > 49'h8000_0000) ? 49'h8000_0000 : mag;
      return ~lim[31:0] + 32'd1;
    end
    return (mag > 49'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      done <= 1'b0;
    end else begin
      f1_v <= gain.valid;
      f2_v <= f1_v;
      done <= f2_v;
    end
  end

  always_ff @(posedge clk) begin
    // weighted pair products
    v_yz <= pv_yz[63:24];
    v_xz <= pv_xz[63:24];
    v_xy <= pv_xy[63:24];
    n1_x <= sb ^ side.neg_y ^ side.neg_z;
    n1_y <= ~(sb ^ side.neg_x ^ side.neg_z);
    n1_z <= sb ^ side.neg_x ^ side.neg_y;
    // magnitude products in two halves
    hi_yz <= 56'(v_yz) * 56'(bmag[31:16]);
    lo_yz <= 56'(v_yz) * 56'(bmag[15:0]);
    hi_xz <= 56'(v_xz) * 56'(bmag[31:16]);
    lo_xz <= 56'(v_xz) * 56'(bmag[15:0]);
    hi_xy <= 56'(v_xy) * 56'(bmag[31:16]);
    lo_xy <= 56'(v_xy) * 56'(bmag[15:0]);
    n2_x  <= n1_x;
    n2_y  <= n1_y;
    n2_z  <= n1_z;
    // halved x and z components, full y component
    field.field_x <= finish({1'b0, sum_yz[56:9]}, n2_x);
    field.field_y <= finish(sum_xz[56:8], n2_y);
    field.field_z <= finish({1'b0, sum_xy[56:9]}, n2_z);
  end

endmodule

[rtl/core/gaussian_field_evaluate.sv]
// Gaussian pulse initial electric field evaluator.
// A point (pos_x, pos_y, pos_z) is taken at a rising edge where start is
// high and busy is low; busy is always low, so a point may be offered in
// every cycle, one point per cycle sustained.
// Each point yields one result: done is high for exactly one cycle with
// field_x, field_y and field_z on the field port in that cycle.
// The pipeline has 5 front-end stages (magnitudes, squares, radius,
// width product, argument), 21 exponential stages (split, ln 2 scale, nine
// Horner steps of two stages each, final scale) and 3 output stages.
// Width coefficient and magnitude are written through cfg_write,
// cfg_index and cfg_data; write them only while no point is in flight.
// Reset empties the pipeline (beats in flight are dropped, none is produced afterwards) and
// returns width coefficient and magnitude to 1.0.
// The receiver cannot stall: every result is shown for one cycle only.
module gaussian_field_evaluate (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  gfe_pkg::point_t                     point,
  input  logic                                cfg_write,
  input  logic [gfe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data,
  output logic                                done,
  output gfe_pkg::field_t                     field
);

  logic [31:0]    width_coef;
  logic [31:0]    magnitude;
  gfe_pkg::arg_t  arg;
  gfe_pkg::side_t side;
  gfe_pkg::side_t side_dly [gfe_pkg::EXP_LAT];
  gfe_pkg::gain_t gain;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_coef <= gfe_pkg::WIDTH_COEF_RESET;
      magnitude  <= gfe_pkg::MAGNITUDE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        gfe_pkg::REG_WIDTH_COEF: width_coef <= cfg_data;
        gfe_pkg::REG_MAGNITUDE:  magnitude  <= cfg_data;
        default: ;
      endcase
    end
  end

  gfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start & ~busy),
    .point      (point),
    .width_coef (width_coef),
    .arg        (arg),
    .side       (side)
  );

  gfe_exp u_exp (
    .clk  (clk),
    .rst  (rst),
    .arg  (arg),
    .gain (gain)
  );

  // pair products wait alongside the exponential unit
  always_ff @(posedge clk) begin
    side_dly[0] <= side;
    for (int i = 1; i < gfe_pkg::EXP_LAT; i++) begin
      side_dly[i] <= side_dly[i-1];
    end
  end

  gfe_field u_field (
    .clk       (clk),
    .rst       (rst),
    .gain      (gain),
    .side      (side_dly[gfe_pkg::EXP_LAT-1]),
    .magnitude (magnitude),
    .done      (done),
    .field     (field)
  );

endmodule

[tb/sv/gaussian_field_evaluate_tb.sv]
module gaussian_field_evaluate_tb;

  localparam int PIPE_LAT = 29;
  localparam int N_RANDOM = 1030;

  // expected field results of accepted points, oldest first
  class field_board;
    gfe_pkg::field_t pending[$];
    int errors;
    int checked;
    logic [31:0] coef;
    logic [31:0] mag;

    function new();
      errors = 0;
      checked = 0;
      coef = gfe_pkg::WIDTH_COEF_RESET;
      mag = gfe_pkg::MAGNITUDE_RESET;
    endfunction

    // exp(-t) in q0.24, t in q.24
    function logic [63:0] gauss_weight(logic [63:0] t);
      logic [63:0] u, n, f, w, s, g;
      if (t >= (64'd17 << 24)) return 64'd0;
      u = (t * 64'd1549082005) >> 30;
      n = u >> 24;
      f = u & 64'hFF_FFFF;
      w = (f * 64'd2977044472) >> 24;
      s = 64'h1_0000_0000;
      for (int i = 9; i >= 1; i--) begin
        s = 64'h1_0000_0000 - ((w * s) >> 32) / i;
      end
      g = (s + (64'd1 << (7 + n))) >> (8 + n);
      return (g > 64'hFF_FFFF) ? 64'hFF_FFFF : g;
    endfunction

    // one saturated field component from a coordinate pair
    function logic [31:0] component(logic [63:0] pa, logic [63:0] pb, logic [63:0] g,
                                    logic [63:0] bm, bit neg, int sh);
      logic [63:0] m, v, hi, lo, amt;
      m = (pa * pb) >> 24;
      v = (m * g) >> 24;
      hi = v * (bm >> 16);
      lo = v * (bm & 64'hFFFF);
      amt = (hi + (lo >> 16)) >> (sh - 16);
      if (amt == 0) return 32'd0;
      if (neg) begin
        if (amt > 64'h8000_0000) amt = 64'h8000_0000;
        return 32'(64'h1_0000_0000 - amt);
      end
      return (amt > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : amt[31:0];
    endfunction

    // note an accepted point
    function void add_point(gfe_pkg::point_t p);
      logic [63:0] ax, ay, az, bm, r2, ph, pl, t, g;
      gfe_pkg::field_t e;
      ax = {32'd0, gfe_pkg::abs32(p.pos_x)};
      ay = {32'd0, gfe_pkg::abs32(p.pos_y)};
      az = {32'd0, gfe_pkg::abs32(p.pos_z)};
      bm = {32'd0, gfe_pkg::abs32(mag)};
      r2 = (ax * ax + ay * ay + az * az) >> 24;
      ph = {32'd0, coef} * (r2 >> 20);
      pl = {32'd0, coef} * (r2 & 64'hF_FFFF);
      if (ph >= (64'd1 << 40)) t = 64'd17 << 24;
      else t = ((ph << 20) + pl) >> 24;
      g = gauss_weight(t);
      e.field_x = component(ay, az, g, bm, mag[31] ^ p.pos_y[31] ^ p.pos_z[31], 25);
      e.field_y = component(ax, az, g, bm, !(mag[31] ^ p.pos_x[31] ^ p.pos_z[31]), 24);
      e.field_z = component(ax, ay, g, bm, mag[31] ^ p.pos_x[31] ^ p.pos_y[31], 25);
      pending.push_back(e);
    endfunction

    // compare one result beat
    function void check_field(gfe_pkg::field_t a);
      gfe_pkg::field_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.field_x !== e.field_x) begin
        $display("%0t: field_x expected %h actual %h", $time, e.field_x, a.field_x);
        errors++;
      end
      if (a.field_y !== e.field_y) begin
        $display("%0t: field_y expected %h actual %h", $time, e.field_y, a.field_y);
        errors++;
      end
      if (a.field_z !== e.field_z) begin
        $display("%0t: field_z expected %h actual %h", $time, e.field_z, a.field_z);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  gfe_pkg::point_t point = '0;
  logic cfg_write = 1'b0;
  logic [gfe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic done;
  gfe_pkg::field_t field;

  field_board board = new();
  int n_points = 0;

  gaussian_field_evaluate DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .field(field)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) board.check_field(field);
  end

  // offer one point beat and wait for it to be taken; start stays high
  // after the beat so that back to back points need no extra edge
  task automatic send_point(gfe_pkg::point_t p);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    point <= p;
    do @(posedge clk); while (busy);
    board.add_point(p);
    n_points++;
  endtask

  // idle then write one register
  task automatic write_reg(logic [gfe_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] val);
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == gfe_pkg::REG_WIDTH_COEF) board.coef = val;
    else board.mag = val;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      2: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
      3: return 32'($signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
      default: return 32'($signed($urandom_range(0, 32'h0001_0000)) - 32'sh0000_8000);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0400_0000);
      2: return $urandom_range(0, 32'h0010_0000);
      default: return 32'h0100_0000;
    endcase
  endfunction

  initial begin
    gfe_pkg::point_t p;
    logic [31:0] dir_val[8];
    dir_val = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000,
                32'hFF00_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0080_0000};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme coordinates, origin, far points
    for (int i = 0; i < 8; i++) begin
      p.pos_x = dir_val[i];
      p.pos_y = dir_val[(i + 3) % 8];
      p.pos_z = dir_val[(i + 5) % 8];
      send_point(p);
    end
    p = '{32'h0, 32'h0, 32'h0};
    send_point(p);
    p = '{32'h0080_0000, 32'hFF80_0000, 32'h0040_0000};
    send_point(p);
    // large and most negative magnitudes so outputs saturate, zero and full width, zero magnitude
    write_reg(gfe_pkg::REG_MAGNITUDE, 32'h7FFF_FFFF);
    write_reg(gfe_pkg::REG_WIDTH_COEF, 32'h0);
    p = '{32'h0800_0000, 32'hF800_0000, 32'h0800_0000};
    send_point(p);
    p = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    send_point(p);
    write_reg(gfe_pkg::REG_MAGNITUDE, 32'h8000_0000);
    send_point(p);
    p = '{32'h0100_0000, 32'h0100_0000, 32'hFF00_0000};
    send_point(p);
    write_reg(gfe_pkg::REG_WIDTH_COEF, 32'hFFFF_FFFF);
    send_point(p);
    write_reg(gfe_pkg::REG_MAGNITUDE, 32'h0);
    send_point(p);
    write_reg(gfe_pkg::REG_MAGNITUDE, gfe_pkg::MAGNITUDE_RESET);
    write_reg(gfe_pkg::REG_WIDTH_COEF, gfe_pkg::WIDTH_COEF_RESET);

    // random phases with fresh settings
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 50) begin
        write_reg(gfe_pkg::REG_WIDTH_COEF, rand_coef());
        write_reg(gfe_pkg::REG_MAGNITUDE, ($urandom_range(0, 3) == 0) ? $urandom()
                  : 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000));
      end
      p.pos_x = rand_coord();
      p.pos_y = rand_coord();
      p.pos_z = rand_coord();
      send_point(p);
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
    $display("points sent %0d, results checked %0d, over several width and magnitude settings",
             n_points, board.checked);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
